### sv/ted_pkg.sv
// ----------------------------------------------------------------------------
// Touch event decoder package
// Shared request, response and configuration types, event codes and the
// coordinate clamp used by the decode logic.
// ----------------------------------------------------------------------------
package ted_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FINE_RES     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALTED       = 2'd3;
   localparam int unsigned CSR_DATA_W = 17;

   // Reset values of the configuration registers
   localparam logic [16:0] WIDTH_LIMIT_RST  = 17'd1080;
   localparam logic [16:0] HEIGHT_LIMIT_RST = 17'd2400;

   // Event identifiers
   localparam logic [7:0] EV_NONE   = 8'h00;
   localparam logic [7:0] EV_READY  = 8'h03;
   localparam logic [7:0] EV_ENTER  = 8'h13;
   localparam logic [7:0] EV_MOTION = 8'h23;
   localparam logic [7:0] EV_LEAVE  = 8'h33;

   // Action codes on the response
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_CONTACT = 3'd1;
   localparam logic [2:0] ACT_UP      = 3'd2;
   localparam logic [2:0] ACT_SCAN    = 3'd3;
   localparam logic [2:0] ACT_RELEASE = 3'd4;

   // Input operations
   localparam logic OP_DECODE  = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Widest slot count the mask logic is built for
   localparam int unsigned MASK_MAX_W = 16;

   typedef struct packed {
      logic       operation;
      logic       first_in_frame;
      logic       last_in_frame;
      logic [7:0] byte_zero;
      logic [7:0] byte_one;
      logic [7:0] byte_two;
      logic [7:0] byte_three;
      logic [7:0] byte_four;
      logic [7:0] byte_five;
      logic [7:0] byte_six;
      logic [7:0] byte_seven;
   } req_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [3:0]        slot;
      logic [15:0]       x_pos;
      logic [15:0]       y_pos;
      logic [9:0]        major_axis;
      logic [9:0]        minor_axis;
      logic signed [7:0] angle;
      logic              key_update;
      logic              key_value;
      logic [9:0]        active_mask;
      logic [4:0]        events_remaining;
      logic              frame_sync;
   } rsp_type;

   typedef struct packed {
      logic [16:0] width_limit;
      logic [16:0] height_limit;
      logic        fine_resolution;
      logic        halted;
   } cfg_type;

   // Clamp a coordinate to 0 .. limit-1; a zero limit acts as one and any
   // limit of 65536 or more as 65536.
   function automatic logic [15:0] clamp_coord(input logic [15:0] value,
                                               input logic [16:0] limit);
      logic [15:0] top;
      if (limit == 17'd0) begin
         top = 16'd0;
      end else if (limit[16]) begin
         top = 16'hFFFF;
      end else begin
         top = limit[15:0] - 16'd1;
      end
      return (value > top) ? top : value;
   endfunction

endpackage

### sv/ted_cfg.sv
// ----------------------------------------------------------------------------
// Touch event decoder configuration registers
// Holds the coordinate limits, resolution mode and halt flag, written
// through the csr channel, which is always ready.
// ----------------------------------------------------------------------------
module ted_cfg
   import ted_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH_LIMIT:  cfg_in.width_limit     = csr_wdata;
            CSR_HEIGHT_LIMIT: cfg_in.height_limit    = csr_wdata;
            CSR_FINE_RES:     cfg_in.fine_resolution = csr_wdata[0];
            CSR_HALTED:       cfg_in.halted          = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_limit     <= WIDTH_LIMIT_RST;
         cfg_ff.height_limit    <= HEIGHT_LIMIT_RST;
         cfg_ff.fine_resolution <= 1'b1;
         cfg_ff.halted          <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/ted_decode.sv
// ----------------------------------------------------------------------------
// Touch event decoder event logic
// Combinational decode of one registered request against the current slot
// mask and skip flag; gives the response and the next state.
// ----------------------------------------------------------------------------
module ted_decode
   import ted_pkg::*;
#(
   parameter int unsigned SLOT_COUNT = 10
)
(
   input  req_type                req,
   input  cfg_type                cfg,
   input  logic [SLOT_COUNT-1:0]  slot_mask,
   input  logic                   skip_rest,
   output rsp_type                rsp,
   output logic [SLOT_COUNT-1:0]  slot_mask_next,
   output logic                   skip_rest_next
);

   localparam logic [4:0] SLOT_LIMIT = 5'(SLOT_COUNT);

   logic [3:0]            slot_num;
   logic                  slot_ok;
   logic [SLOT_COUNT-1:0] slot_bit;
   logic [SLOT_COUNT-1:0] mask_set;
   logic [SLOT_COUNT-1:0] mask_clr;
   logic [15:0]           raw_x;
   logic [15:0]           raw_y;
   logic                  skip_eff;

   assign slot_num = req.byte_one[7:4];
   assign slot_ok  = ({1'b0, slot_num} < SLOT_LIMIT);

   // One-hot of the slot number over the tracked slots
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         slot_bit[i] = (slot_num == 4'(i));
      end
   end

   assign mask_set = slot_mask | slot_bit;
   assign mask_clr = slot_mask & ~slot_bit;

   // Raw coordinates, fine or packed layout
   always_comb begin
      if (cfg.fine_resolution) begin
         raw_x = {req.byte_three, req.byte_two};
         raw_y = {req.byte_five, req.byte_four};
      end else begin
         raw_x = {4'd0, req.byte_three[3:0], req.byte_two};
         raw_y = {4'd0, req.byte_four, req.byte_three[7:4]};
      end
   end

   assign skip_eff = req.first_in_frame ? 1'b0 : skip_rest;

   // Event decode
   always_comb begin
      rsp                  = '0;
      rsp.events_remaining = req.byte_seven[4:0];
      slot_mask_next       = slot_mask;
      skip_rest_next       = skip_rest;
      if (cfg.halted) begin
         // suspended: no action reported, keep state
      end else if (req.operation == OP_RELEASE) begin
         slot_mask_next  = '0;
         rsp.action      = ACT_RELEASE;
         rsp.key_update  = 1'b1;
         rsp.frame_sync  = 1'b1;
      end else begin
         skip_rest_next = skip_eff;
         rsp.frame_sync = req.last_in_frame;
         if (!skip_eff) begin
            unique case (req.byte_zero) inside
               EV_NONE: begin
                  skip_rest_next = 1'b1;
               end
               EV_ENTER, EV_MOTION: begin
                  if (slot_ok) begin
                     rsp.action     = ACT_CONTACT;
                     rsp.slot       = slot_num;
                     rsp.x_pos      = clamp_coord(raw_x, cfg.width_limit);
                     rsp.y_pos      = clamp_coord(raw_y, cfg.height_limit);
                     rsp.major_axis = {req.byte_zero[3:2], req.byte_six[7:4], 4'd0};
                     rsp.minor_axis = {req.byte_seven[7:6], req.byte_six[3:0], 4'd0};
                     rsp.angle      = req.byte_five;
                     rsp.key_update = 1'b1;
                     rsp.key_value  = 1'b1;
                     slot_mask_next = mask_set;
                  end
               end
               EV_LEAVE: begin
                  if (slot_ok) begin
                     rsp.action     = ACT_UP;
                     rsp.slot       = slot_num;
                     slot_mask_next = mask_clr;
                     rsp.key_update = (mask_clr == '0);
                  end
               end
               EV_READY: begin
                  rsp.action = ACT_SCAN;
               end
               default: begin
                  rsp.action = ACT_NONE;
               end
            endcase
         end
      end
      // Only the low ten slots are visible on the response
      rsp.active_mask = 10'(MASK_MAX_W'(slot_mask_next));
   end

endmodule

### sv/ted_pipe.sv
// ----------------------------------------------------------------------------
// Touch event decoder pipeline
// Request register, decode logic, slot state and response register; one
// request may enter every cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module ted_pipe
   import ted_pkg::*;
#(
   parameter int unsigned SLOT_COUNT = 10
)
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic                  in_valid_ff;
   logic                  in_valid_in;
   req_type               in_data_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   rsp_type               out_data_ff;
   logic [SLOT_COUNT-1:0] mask_ff;
   logic [SLOT_COUNT-1:0] mask_in;
   logic                  skip_ff;
   logic                  skip_in;
   rsp_type               dec_rsp;
   logic                  advance;

   ted_decode #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_decode (
      .req            (in_data_ff),
      .cfg            (cfg),
      .slot_mask      (mask_ff),
      .skip_rest      (skip_ff),
      .rsp            (dec_rsp),
      .slot_mask_next (mask_in),
      .skip_rest_next (skip_in)
   );

   // Move the held request on when the response register is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mask_ff      <= '0;
         skip_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mask_ff <= mask_in;
            skip_ff <= skip_in;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= dec_rsp;
      end
   end

endmodule

### sv/touch_event_decoder_unit.sv
// ----------------------------------------------------------------------------
// Touch event decoder
// Decodes one 8-byte touch controller event per request into one response.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one event (or a release-all operation) per request, valid/ready.
//   rsp_*  : one response per request, in order, valid/ready.
//   csr_*  : register writes (limits, resolution mode, halt), always ready;
//            write only while no request is in flight.
// Path: an accepted request is held in the request register, decoded into
//   the response register once that register is free, and offered from there.
// Throughput: one request per cycle while rsp_ready is high; all decode, clamp
//   and slot mask work sits between the request and response registers.
// Reset: slot mask and frame skip flag clear, registers take their reset
//   values (width 1080, height 2400, fine mode, not halted), no request
//   or response is held.
// Stall: while rsp_ready is low the response register holds; one further
//   request is taken into the request register, then req_ready drops.
// ----------------------------------------------------------------------------
module touch_event_decoder_unit
   import ted_pkg::*;
#(
   parameter int unsigned SLOT_COUNT = 10
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type cfg;

   ted_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ted_pipe #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### dv/ted_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch event decoder checker
// Watches the request, response and register write channels of the touch
// event decoder. Every accepted request is run through a local decode model
// with its own register shadow, slot mask and frame skip flag; each accepted
// response is then compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ted_checker
   import ted_pkg::*;
#(
   parameter int unsigned SLOT_COUNT = 10
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     error_count,
   output int                     pending_count,
   output int                     checked_count
);

   // Local copies of the registers and of the decoder state
   cfg_type     shadow_cfg;
   logic [15:0] contact_mask;
   logic        skip_frame;
   rsp_type     expected_reports[$];

   // Limit a coordinate to 0 .. limit-1, zero limit treated as one,
   // anything past 65536 treated as 65536
   function automatic logic [15:0] limit_coord(input logic [15:0] value,
                                               input logic [16:0] limit);
      logic [16:0] bound;
      bound = limit;
      if (bound == 17'd0) bound = 17'd1;
      if (bound > 17'd65536) bound = 17'd65536;
      return ({1'b0, value} > bound - 17'd1) ? 16'(bound - 17'd1) : value;
   endfunction

   // Predict the response of one request and advance the local state
   function automatic rsp_type decode_touch_event(input req_type item);
      rsp_type     rsp;
      logic [3:0]  slot_no;
      logic [15:0] raw_x;
      logic [15:0] raw_y;
      rsp = '0;
      slot_no = item.byte_one[7:4];
      rsp.events_remaining = item.byte_seven[4:0];
      if (shadow_cfg.halted) begin
         // suspended: nothing moves
      end else if (item.operation == OP_RELEASE) begin
         contact_mask = '0;
         rsp.action = ACT_RELEASE;
         rsp.key_update = 1'b1;
         rsp.frame_sync = 1'b1;
      end else begin
         if (item.first_in_frame) skip_frame = 1'b0;
         rsp.frame_sync = item.last_in_frame;
         if (!skip_frame) begin
            case (item.byte_zero)
               EV_NONE: begin
                  skip_frame = 1'b1;
               end
               EV_ENTER, EV_MOTION: begin
                  if (slot_no < SLOT_COUNT) begin
                     if (shadow_cfg.fine_resolution) begin
                        raw_x = {item.byte_three, item.byte_two};
                        raw_y = {item.byte_five, item.byte_four};
                     end else begin
                        raw_x = {4'b0000, item.byte_three[3:0], item.byte_two};
                        raw_y = {4'b0000, item.byte_four, item.byte_three[7:4]};
                     end
                     rsp.action = ACT_CONTACT;
                     rsp.slot = slot_no;
                     rsp.x_pos = limit_coord(raw_x, shadow_cfg.width_limit);
                     rsp.y_pos = limit_coord(raw_y, shadow_cfg.height_limit);
                     rsp.major_axis = {item.byte_zero[3:2], item.byte_six[7:4], 4'b0000};
                     rsp.minor_axis = {item.byte_seven[7:6], item.byte_six[3:0], 4'b0000};
                     rsp.angle = item.byte_five;
                     rsp.key_update = 1'b1;
                     rsp.key_value = 1'b1;
                     contact_mask[slot_no] = 1'b1;
                  end
               end
               EV_LEAVE: begin
                  if (slot_no < SLOT_COUNT) begin
                     rsp.action = ACT_UP;
                     rsp.slot = slot_no;
                     contact_mask[slot_no] = 1'b0;
                     if (contact_mask == '0) rsp.key_update = 1'b1;
                  end
               end
               EV_READY: begin
                  rsp.action = ACT_SCAN;
               end
               default: ;
            endcase
         end
      end
      rsp.active_mask = contact_mask[9:0];
      return rsp;
   endfunction

   // One line per mismatch
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ted_checker: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   task automatic check_report(input rsp_type got, input rsp_type want);
      if (got.action !== want.action) report_mismatch("action", got.action, want.action);
      if (got.slot !== want.slot) report_mismatch("slot", got.slot, want.slot);
      if (got.x_pos !== want.x_pos) report_mismatch("x_pos", got.x_pos, want.x_pos);
      if (got.y_pos !== want.y_pos) report_mismatch("y_pos", got.y_pos, want.y_pos);
      if (got.major_axis !== want.major_axis)
         report_mismatch("major_axis", got.major_axis, want.major_axis);
      if (got.minor_axis !== want.minor_axis)
         report_mismatch("minor_axis", got.minor_axis, want.minor_axis);
      if (got.angle !== want.angle) report_mismatch("angle", got.angle, want.angle);
      if (got.key_update !== want.key_update)
         report_mismatch("key_update", got.key_update, want.key_update);
      if (got.key_value !== want.key_value)
         report_mismatch("key_value", got.key_value, want.key_value);
      if (got.active_mask !== want.active_mask)
         report_mismatch("active_mask", got.active_mask, want.active_mask);
      if (got.events_remaining !== want.events_remaining)
         report_mismatch("events_remaining", got.events_remaining, want.events_remaining);
      if (got.frame_sync !== want.frame_sync)
         report_mismatch("frame_sync", got.frame_sync, want.frame_sync);
   endtask

   // Channel monitor: register writes first, then requests, then responses
   always @(posedge clock) begin
      if (reset) begin
         shadow_cfg = '{WIDTH_LIMIT_RST, HEIGHT_LIMIT_RST, 1'b1, 1'b0};
         contact_mask = '0;
         skip_frame = 1'b0;
         expected_reports.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIDTH_LIMIT:  shadow_cfg.width_limit = csr_wdata;
               CSR_HEIGHT_LIMIT: shadow_cfg.height_limit = csr_wdata;
               CSR_FINE_RES:     shadow_cfg.fine_resolution = csr_wdata[0];
               CSR_HALTED:       shadow_cfg.halted = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_reports.push_back(decode_touch_event(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               report_mismatch("response with no request waiting", rsp_data.action, '0);
            end else begin
               check_report(rsp_data, expected_reports.pop_front());
               checked_count++;
            end
         end
      end
      pending_count = expected_reports.size();
   end

endmodule

### dv/tb_touch_event_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch event decoder testbench
// Drives a short directed run of corner events after reset, then frames of
// random events under seven register settings (zero, unit, huge and random
// limits, both coordinate modes, halted). The sender runs in bursts, the
// receiver stalls in changing patterns; a side checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_touch_event_decoder_unit;
   import ted_pkg::*;

   localparam int unsigned SLOT_COUNT   = 10;
   localparam int unsigned IDLE_LIMIT   = 5000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned PHASE_COUNT  = 7;
   localparam logic [7:0]  EV_UNKNOWN   = 8'h42;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int error_count;
   int pending_count;
   int checked_count;
   int burst_left = 0;
   int requests_sent = 0;
   int releases_sent = 0;
   int settings_used = 1;
   int stall_mode = 0;
   int stall_left = 0;
   int idle_cycles = 0;

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   touch_event_decoder_unit #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ted_checker #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // Response back-pressure: one of four patterns, redrawn when its countdown ends
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(64, 256);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 7) != 0);
         default: rsp_ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_touch_event_decoder_unit: done, errors");
         $finish;
      end
   end

   // Present one request, with burst gaps between groups of requests
   task automatic push_request(input req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      burst_left--;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      if (item.operation == OP_RELEASE) releases_sent++;
   endtask

   // Stop sending and wait for every outstanding response
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   initial begin
      int          quota;
      int          issued;
      int          frame_len;
      int          pick;
      logic [16:0] w_lim;
      logic [16:0] h_lim;
      logic        fine_mode;
      logic        halt_mode;
      logic        op;
      logic        first;
      logic        last;
      logic [7:0]  id;
      logic [3:0]  slot_nib;
      logic [63:0] bytes;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed corners under reset settings (1080 x 2400, 16-bit coordinates)
      // enter with bytes two to seven high: both clamps, largest minor axis, angle -1
      push_request(req_type'({OP_DECODE, 1'b1, 1'b0, EV_ENTER, 8'h0F, 48'hFFFF_FFFF_FFFF}));
      // highest valid slot, all zero payload
      push_request(req_type'({OP_DECODE, 1'b0, 1'b0, EV_MOTION, 8'h90, 48'h0}));
      // slots past the count are ignored
      push_request(req_type'({OP_DECODE, 1'b0, 1'b0, EV_ENTER, 8'hA5, 48'h3412_7856_A55A}));
      push_request(req_type'({OP_DECODE, 1'b0, 1'b0, EV_MOTION, 8'hF0, 48'hFFFF_FFFF_FFFF}));
      // x exactly at the top, y one past it
      push_request(req_type'({OP_DECODE, 1'b0, 1'b0, EV_MOTION, 8'h00, 48'h3704_6009_C3C1}));
      // leave with a contact still down, then the last contact
      push_request(req_type'({OP_DECODE, 1'b0, 1'b0, EV_LEAVE, 8'h90, 48'h0}));
      push_request(req_type'({OP_DECODE, 1'b0, 1'b0, EV_LEAVE, 8'h00, 48'h0}));
      push_request(req_type'({OP_DECODE, 1'b0, 1'b1, EV_READY, 8'h00, 48'h0000_0000_001F}));
      push_request(req_type'({OP_DECODE, 1'b1, 1'b0, EV_UNKNOWN, 8'h30, 48'h1122_3344_5566}));
      // no-event skips the rest of its frame, frame sync still follows
      push_request(req_type'({OP_DECODE, 1'b1, 1'b0, EV_NONE, 8'h00, 48'h0000_0000_0003}));
      push_request(req_type'({OP_DECODE, 1'b0, 1'b0, EV_ENTER, 8'h10, 48'h5555_5555_5542}));
      push_request(req_type'({OP_DECODE, 1'b0, 1'b1, EV_LEAVE, 8'h10, 48'hAAAA_AAAA_AA81}));
      // new frame clears the skip; angle -128
      push_request(req_type'({OP_DECODE, 1'b1, 1'b0, EV_ENTER, 8'h20, 48'h0100_0280_66C7}));
      push_request(req_type'({OP_RELEASE, 1'b0, 1'b0, 64'h5AA5_C33C_0FF0_9669}));
      push_request(req_type'({OP_DECODE, 1'b0, 1'b0, EV_LEAVE, 8'h20, 48'h0}));
      push_request(req_type'({OP_DECODE, 1'b0, 1'b0, EV_ENTER, 8'h3C, 48'h0}));
      push_request(req_type'({OP_RELEASE, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF}));
      hold_until_drained();

      // Random frames, one register setting per phase
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         fine_mode = 1'b1;
         halt_mode = 1'b0;
         case (phase)
            0: begin w_lim = WIDTH_LIMIT_RST; h_lim = HEIGHT_LIMIT_RST; quota = 250; end
            1: begin w_lim = 17'd0; h_lim = 17'd1; fine_mode = 1'b0; quota = 250; end
            2: begin w_lim = 17'd65536; h_lim = 17'h1FFFF; quota = 300; end
            3: begin w_lim = 17'd3000; h_lim = 17'd1000; fine_mode = 1'b0; quota = 300; end
            4: begin
               w_lim = 17'($urandom_range(1, 65536));
               h_lim = 17'($urandom_range(1, 65536));
               halt_mode = 1'b1;
               quota = 80;
            end
            5: begin
               w_lim = 17'($urandom_range(1, 65536));
               h_lim = 17'($urandom_range(1, 65536));
               fine_mode = 1'($urandom_range(0, 1));
               quota = 350;
            end
            default: begin
               w_lim = WIDTH_LIMIT_RST;
               h_lim = HEIGHT_LIMIT_RST;
               fine_mode = 1'b0;
               quota = 480;
            end
         endcase
         if (phase != 0) begin
            hold_until_drained();
            repeat (DRAIN_CYCLES) @(negedge clock);
            write_register(CSR_WIDTH_LIMIT, w_lim);
            write_register(CSR_HEIGHT_LIMIT, h_lim);
            write_register(CSR_FINE_RES, CSR_DATA_W'(fine_mode));
            write_register(CSR_HALTED, CSR_DATA_W'(halt_mode));
            @(negedge clock);
            csr_valid <= 1'b0;
            settings_used++;
         end

         issued = 0;
         while (issued < quota) begin
            frame_len = $urandom_range(1, 8);
            for (int k = 0; k < frame_len && issued < quota; k++) begin
               // mid-phase: let everything outstanding come back
               if (issued == quota / 2) hold_until_drained();
               pick = $urandom_range(0, 99);
               op = OP_DECODE;
               first = (k == 0);
               last = (k == frame_len - 1);
               slot_nib = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, SLOT_COUNT - 1))
                                                       : 4'($urandom_range(SLOT_COUNT, 15));
               bytes = {$urandom, $urandom};
               // small high bytes so coordinates land near the limits
               if ($urandom_range(0, 1)) bytes[39:32] = 8'($urandom_range(0, 12));
               if ($urandom_range(0, 1)) bytes[23:16] = 8'($urandom_range(0, 12));
               bytes[4:0] = 5'(frame_len - 1 - k);
               if (pick < 40) id = EV_ENTER;
               else if (pick < 65) id = EV_MOTION;
               else if (pick < 82) id = EV_LEAVE;
               else if (pick < 85) id = EV_READY;
               else if (pick < 88) id = EV_NONE;
               else id = 8'($urandom);
               if (pick >= 94 && pick < 97) op = OP_RELEASE;
               bytes[63:52] = {id, slot_nib};
               // broken framing now and then
               if (pick >= 97) begin
                  first = 1'($urandom_range(0, 1));
                  last = 1'($urandom_range(0, 1));
               end
               push_request(req_type'({op, first, last, bytes}));
               issued++;
            end
         end
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb_touch_event_decoder_unit: %0d requests (%0d release-all) across %0d settings",
               requests_sent, releases_sent, settings_used);
      $display("tb_touch_event_decoder_unit: %0d responses compared, %0d mismatches",
               checked_count, error_count);
      if (error_count == 0) begin
         $display("tb_touch_event_decoder_unit: done, clean");
      end else begin
         $display("tb_touch_event_decoder_unit: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
sv/ted_pkg.sv
sv/ted_cfg.sv
sv/ted_decode.sv
sv/ted_pipe.sv
sv/touch_event_decoder_unit.sv
dv/ted_checker.sv
dv/tb_touch_event_decoder_unit.sv
